[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that holds at every edge outside reset
`define QDP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the cycle after a trigger
`define QDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/qdp_pkg.sv]
`timescale 1ns / 1ps
package qdp_pkg;

  localparam int VECTOR_BYTES_DEF = 64;
  localparam int POS_W            = 3;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = QPTR_W + 1;

  localparam logic MODE_INT8  = 1'b0;
  localparam logic MODE_INT16 = 1'b1;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

  typedef struct packed {
    logic [63:0]      a;
    logic [63:0]      b;
    logic             last;
    logic [POS_W-1:0] pos;
    logic             mode;
  } item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic valid;
    logic mode;
  } snap_ctl_t;

  // Clamp a 17-bit signed value into int16
  function automatic logic [15:0] sat16(input logic [16:0] v);
    logic [15:0] r;
    r = v[15:0];
    if (!v[16] && v[15]) r = 16'h7FFF;
    else if (v[16] && !v[15]) r = 16'h8000;
    return r;
  endfunction

  // Saturating int16 add
  function automatic logic [15:0] sat_add16(input logic [15:0] x, input logic [15:0] y);
    logic [16:0] s;
    s = {x[15], x} + {y[15], y};
    return sat16(s);
  endfunction

  // A negated with 8-bit wrap where B is negative, times |B|
  function automatic logic [15:0] prod8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0]         ua;
    logic [8:0]         mag;
    logic signed [17:0] sa;
    logic signed [17:0] sm;
    logic signed [17:0] p;
    ua  = b[7] ? (8'd0 - a) : a;
    mag = b[7] ? (9'd256 - {1'b0, b}) : {1'b0, b};
    sa  = {{10{ua[7]}}, ua};
    sm  = {9'd0, mag};
    p   = sa * sm;
    return p[15:0];
  endfunction

  // Leading zeros of a byte, 8 when zero
  function automatic logic [3:0] lzc8(input logic [7:0] v);
    logic [3:0] n;
    logic       found;
    n     = 4'd8;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 4'(7 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

[design/qdp_front.sv]
`timescale 1ns / 1ps
module qdp_front import qdp_pkg::*; #(
  parameter int VECTOR_BYTES = VECTOR_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        last_i,
  input  logic        mode_i,
  input  logic        q_full_i,
  output logic        push_o,
  output item_t       item_o
);

  localparam int CHUNKS = VECTOR_BYTES / 8;

  logic [POS_W-1:0] pos_q, pos_d;

  assign s_tready_o = !q_full_i;
  assign push_o     = s_tvalid_i && !q_full_i;

  // Tag the request with its chunk position and element mode
  always_comb begin
    item_o.a    = a_i;
    item_o.b    = b_i;
    item_o.last = last_i;
    item_o.pos  = pos_q;
    item_o.mode = mode_i;
  end

  // Advance the position, wrap at the vector end or on last
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (last_i || pos_q == POS_W'(CHUNKS - 1)) pos_d = '0;
      else pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pos_q <= '0;
    else pos_q <= pos_d;
  end

endmodule

[design/qdp_queue.sv]
`timescale 1ns / 1ps
module qdp_queue import qdp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   item_o,
  output q_stat_t stat_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign item_o       = mem_q[rd_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // Store requests
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[design/qdp_lane_acc.sv]
`timescale 1ns / 1ps
module qdp_lane_acc import qdp_pkg::*; #(
  parameter int VECTOR_BYTES = VECTOR_BYTES_DEF,
  localparam int LANES = VECTOR_BYTES / 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  in_valid_i,
  input  item_t                 item_i,
  output snap_ctl_t             snap_o,
  output logic [LANES-1:0][15:0] snap_lanes_o
);

  localparam int WIDE = LANES / 2;

  logic                   p_valid_q;
  logic                   p_last_q;
  logic                   p_mode_q;
  logic [POS_W-1:0]       p_pos_q;
  logic [3:0][15:0]       pair8_q, pair8_d;
  logic [3:0][15:0]       prod_lo, prod_hi;
  logic [1:0][31:0]       pair16_q, pair16_d;
  logic [LANES-1:0][15:0] lanes_q, upd_lanes, snap_lanes_q;
  logic [WIDE-1:0][31:0]  sum32;
  logic                   snap_valid_q, snap_mode_q;

  // Pair products of both element modes
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_lo[k]  = prod8(item_i.a[16*k +: 8], item_i.b[16*k +: 8]);
      prod_hi[k]  = prod8(item_i.a[16*k+8 +: 8], item_i.b[16*k+8 +: 8]);
      pair8_d[k]  = sat16({prod_lo[k][15], prod_lo[k]} + {prod_hi[k][15], prod_hi[k]});
    end
    for (int k = 0; k < 2; k++) begin
      pair16_d[k] = {{16{item_i.a[32*k+15]}}, item_i.a[32*k +: 16]}
                  * {{16{item_i.b[32*k+15]}}, item_i.b[32*k +: 16]}
                  + {{16{item_i.a[32*k+31]}}, item_i.a[32*k+16 +: 16]}
                  * {{16{item_i.b[32*k+31]}}, item_i.b[32*k+16 +: 16]};
    end
  end

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_valid_q <= 1'b0;
    else if (adv_i) p_valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_last_q <= item_i.last;
      p_mode_q <= item_i.mode;
      p_pos_q  <= item_i.pos;
      pair8_q  <= pair8_d;
      pair16_q <= pair16_d;
    end
  end

  // Wide lanes in 16-bit mode
  for (genvar j = 0; j < WIDE; j++) begin : g_wide
    assign sum32[j] = {lanes_q[2*j+1], lanes_q[2*j]} + pair16_q[j%2];
  end

  // Each lane updates from its own pair when the position selects it
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    localparam int G8  = i / 4;
    localparam int J   = i / 2;
    localparam int G16 = J / 2;
    logic [15:0] upd8, upd16;
    always_comb begin
      upd8  = sat_add16(lanes_q[i], pair8_q[i%4]);
      upd16 = (i % 2 == 1) ? sum32[J][31:16] : sum32[J][15:0];
      upd_lanes[i] = lanes_q[i];
      if (p_mode_q == MODE_INT16) begin
        if (p_pos_q == POS_W'(G16)) upd_lanes[i] = upd16;
      end else begin
        if (p_pos_q == POS_W'(G8)) upd_lanes[i] = upd8;
      end
    end
  end

  // Accumulate, drop the lanes after a last chunk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q      <= '0;
      snap_valid_q <= 1'b0;
    end else if (adv_i) begin
      snap_valid_q <= p_valid_q && p_last_q;
      if (p_valid_q) lanes_q <= p_last_q ? '0 : upd_lanes;
    end
  end

  // Hold the final lane values for the reduction
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      snap_lanes_q <= upd_lanes;
      snap_mode_q  <= p_mode_q;
    end
  end

  assign snap_o.valid  = snap_valid_q;
  assign snap_o.mode   = snap_mode_q;
  assign snap_lanes_o  = snap_lanes_q;

endmodule

[design/qdp_reduce.sv]
`timescale 1ns / 1ps
module qdp_reduce import qdp_pkg::*; #(
  parameter int VECTOR_BYTES = VECTOR_BYTES_DEF,
  localparam int LANES = VECTOR_BYTES / 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  snap_ctl_t              snap_i,
  input  logic [LANES-1:0][15:0] lanes_i,
  output logic                   valid_o,
  output logic [31:0]            sum_o
);

  localparam int PAIRS  = LANES / 2;
  localparam int LEVELS = $clog2(PAIRS);
  localparam int P2     = 1 << LEVELS;

  logic [31:0]     tree_q [1:2*P2-1];
  logic [P2-1:0][31:0] leaf;
  logic [LEVELS:0] vld_q;

  // Leaf per lane pair: two int16 lanes or one int32 lane
  for (genvar j = 0; j < P2; j++) begin : g_leaf
    if (j < PAIRS) begin : g_used
      always_comb begin
        if (snap_i.mode == MODE_INT16) leaf[j] = {lanes_i[2*j+1], lanes_i[2*j]};
        else leaf[j] = {{16{lanes_i[2*j][15]}}, lanes_i[2*j]}
                     + {{16{lanes_i[2*j+1][15]}}, lanes_i[2*j+1]};
      end
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  // Registered adder tree, one level per cycle while the back end advances
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int j = 0; j < P2; j++) tree_q[P2 + j] <= leaf[j];
      for (int n = 1; n < P2; n++) tree_q[n] <= tree_q[2*n] + tree_q[2*n+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv_i) vld_q <= {vld_q[LEVELS-1:0], snap_i.valid};
  end

  assign valid_o = vld_q[LEVELS];
  assign sum_o   = tree_q[1];

endmodule

[design/qdp_fp_unit.sv]
`timescale 1ns / 1ps
module qdp_fp_unit import qdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [31:0] sum_i,
  input  logic [31:0] scale_i,
  output logic        valid_o,
  output logic [31:0] scaled_o,
  output logic [31:0] raw_o
);

  // valid bits of the seven stages
  logic [6:0] vld_q;
  logic [31:0] raw_q [7];

  // ---- scale decode, free running ----
  logic [23:0] scale_sig;
  logic [23:0] s1_sig_q;
  logic [2:0][3:0] s1_lzb_q;
  logic [31:0] s1_bits_q;
  logic [23:0] sc_ms_q;
  logic signed [9:0] sc_es_q;
  logic sc_nan_q, sc_inf_q, sc_zero_q, sc_sign_q;
  logic [31:0] sc_bits_q;
  logic [4:0] s_lz;

  assign scale_sig = {scale_i[30:23] != 8'd0, scale_i[22:0]};

  always_ff @(posedge clk_i) begin
    s1_bits_q <= scale_i;
    s1_sig_q  <= scale_sig;
    for (int b = 0; b < 3; b++)
      s1_lzb_q[b] <= lzc8(scale_sig[8*b +: 8]);
  end

  always_comb begin
    if (s1_sig_q[23:16] != 8'd0) s_lz = 5'(s1_lzb_q[2]);
    else if (s1_sig_q[15:8] != 8'd0) s_lz = 5'd8 + 5'(s1_lzb_q[1]);
    else s_lz = 5'd16 + 5'(s1_lzb_q[0]);
  end

  always_ff @(posedge clk_i) begin
    sc_bits_q <= s1_bits_q;
    sc_sign_q <= s1_bits_q[31];
    sc_ms_q   <= s1_sig_q << s_lz;
    sc_es_q   <= (s1_bits_q[30:23] == 8'd0) ? (-10'sd126 - $signed({5'd0, s_lz}))
                 : ($signed({2'd0, s1_bits_q[30:23]}) - 10'sd127);
    sc_nan_q  <= (s1_bits_q[30:23] == 8'hFF) && (s1_bits_q[22:0] != '0);
    sc_inf_q  <= (s1_bits_q[30:23] == 8'hFF) && (s1_bits_q[22:0] == '0);
    sc_zero_q <= (s1_bits_q[30:0] == '0);
  end

  // ---- integer to single ----
  logic        f1_sgn_q;
  logic [31:0] f1_mag_q;
  logic        f2_sgn_q;
  logic [31:0] f2_mag_q;
  logic [3:0][3:0] f2_lzb_q;
  logic        f3_sgn_q, f3_zero_q;
  logic [31:0] f3_norm_q;
  logic [5:0]  f3_lz_q;
  logic        f4_sgn_q, f4_zero_q;
  logic [23:0] f4_mx_q;
  logic [5:0]  f4_ex_q;
  logic [5:0]  f_lz;
  logic [24:0] f_mant;
  logic        f_up;

  always_comb begin
    if (f2_mag_q[31:24] != 8'd0) f_lz = 6'(f2_lzb_q[3]);
    else if (f2_mag_q[23:16] != 8'd0) f_lz = 6'd8 + 6'(f2_lzb_q[2]);
    else if (f2_mag_q[15:8] != 8'd0) f_lz = 6'd16 + 6'(f2_lzb_q[1]);
    else f_lz = 6'd24 + 6'(f2_lzb_q[0]);
    f_up   = f3_norm_q[7] && ((f3_norm_q[6:0] != '0) || f3_norm_q[8]);
    f_mant = {1'b0, f3_norm_q[31:8]} + 25'(f_up);
  end

  // ---- multiply and round ----
  logic [47:0] m1_p_q;
  logic signed [9:0] m1_e_q;
  logic        m1_sgn_q, m1_spec_q;
  logic [31:0] m1_sval_q;
  logic [47:0] m2_sig_q;
  logic [7:0]  m2_expf_q;
  logic [4:0]  m2_sh_q;
  logic        m2_ovf_q, m2_sgn_q, m2_spec_q;
  logic [31:0] m2_sval_q;
  logic [23:0] m3_kept_q;
  logic        m3_g_q, m3_st_q;
  logic [7:0]  m3_expf_q;
  logic        m3_ovf_q, m3_sgn_q, m3_spec_q;
  logic [31:0] m3_sval_q;
  logic        m_sgn;
  logic [31:0] m_sval;
  logic        m_spec;
  logic signed [9:0] m_e, m_eb;
  logic [47:0] m_sig, m_shift;
  logic        m_lost;
  logic [30:0] m_field;

  always_comb begin
    m_sgn  = f4_sgn_q ^ sc_sign_q;
    m_spec = 1'b1;
    if (sc_nan_q) m_sval = sc_bits_q | 32'h0040_0000;
    else if (sc_inf_q) m_sval = f4_zero_q ? 32'hFFC0_0000 : {m_sgn, 8'hFF, 23'd0};
    else if (sc_zero_q || f4_zero_q) m_sval = {m_sgn, 31'd0};
    else begin
      m_sval = '0;
      m_spec = 1'b0;
    end
    m_sig   = m1_p_q[47] ? m1_p_q : {m1_p_q[46:0], 1'b0};
    m_e     = m1_p_q[47] ? (m1_e_q + 10'sd1) : m1_e_q;
    m_eb    = m_e + 10'sd127;
    m_shift = m2_sig_q >> m2_sh_q;
    m_lost  = (m2_sig_q & ~({48{1'b1}} << m2_sh_q)) != '0;
    m_field = {m3_expf_q, m3_kept_q[22:0]}
            + 31'(m3_g_q && (m3_st_q || m3_kept_q[0]));
  end

  // Stage registers, payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      raw_q[0]  <= sum_i;
      for (int s = 1; s < 7; s++) raw_q[s] <= raw_q[s-1];
      f1_sgn_q  <= sum_i[31];
      f1_mag_q  <= sum_i[31] ? (32'd0 - sum_i) : sum_i;
      f2_sgn_q  <= f1_sgn_q;
      f2_mag_q  <= f1_mag_q;
      for (int b = 0; b < 4; b++) f2_lzb_q[b] <= lzc8(f1_mag_q[8*b +: 8]);
      f3_sgn_q  <= f2_sgn_q;
      f3_zero_q <= (f2_mag_q == '0);
      f3_lz_q   <= f_lz;
      f3_norm_q <= f2_mag_q << f_lz[4:0];
      f4_sgn_q  <= f3_sgn_q;
      f4_zero_q <= f3_zero_q;
      if (f_mant[24]) begin
        f4_mx_q <= 24'h80_0000;
        f4_ex_q <= 6'd32 - f3_lz_q;
      end else begin
        f4_mx_q <= f_mant[23:0];
        f4_ex_q <= 6'd31 - f3_lz_q;
      end
      m1_p_q    <= 48'(f4_mx_q) * 48'(sc_ms_q);
      m1_e_q    <= $signed({4'd0, f4_ex_q}) + sc_es_q;
      m1_sgn_q  <= m_sgn;
      m1_spec_q <= m_spec;
      m1_sval_q <= m_sval;
      m2_sig_q  <= m_sig;
      m2_ovf_q  <= (m_eb >= 10'sd255);
      m2_sh_q   <= (m_eb <= 10'sd0) ? 5'(10'sd1 - m_eb) : 5'd0;
      m2_expf_q <= (m_eb <= 10'sd0) ? 8'd0 : m_eb[7:0];
      m2_sgn_q  <= m1_sgn_q;
      m2_spec_q <= m1_spec_q;
      m2_sval_q <= m1_sval_q;
      m3_kept_q <= m_shift[47:24];
      m3_g_q    <= m_shift[23];
      m3_st_q   <= (m_shift[22:0] != '0) || m_lost;
      m3_expf_q <= m2_expf_q;
      m3_ovf_q  <= m2_ovf_q;
      m3_sgn_q  <= m2_sgn_q;
      m3_spec_q <= m2_spec_q;
      m3_sval_q <= m2_sval_q;
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv_i) vld_q <= {vld_q[5:0], valid_i};
  end

  // Final pick: special, overflow, or rounded result
  always_comb begin
    if (m3_spec_q) scaled_o = m3_sval_q;
    else if (m3_ovf_q) scaled_o = {m3_sgn_q, 8'hFF, 23'd0};
    else scaled_o = {m3_sgn_q, m_field};
  end

  assign valid_o = vld_q[6];
  assign raw_o   = raw_q[6];

endmodule

[design/quantized_dot_product_engine_top.sv]
`timescale 1ns / 1ps
// Channel   | Dir | Handshake                      | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata {b_chunk, a_chunk}, tlast = last
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata {raw_sum, scaled_value}
// apb       | in  | psel, penable, pwrite, pready  | 0x0 element_mode, 0x4 unquant_scale
//
// One chunk is taken per cycle while the queue is not full; the lane update is a single read-modify-write stage.
// A last chunk's result goes through the adder tree and the conversion/multiply
// pipeline.
// A four-entry queue decouples input from the back end; a stalled output freezes
// the back-end pipeline while the queue keeps taking requests until it is full.
// Reset clears lanes, chunk position, queue and valid bits, and sets the configuration registers to defaults.
`include "assert_macros.svh"
module quantized_dot_product_engine_top import qdp_pkg::*; #(
  parameter int VECTOR_BYTES = VECTOR_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // [63:0] a_chunk, [127:64] b_chunk
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // [31:0] scaled_value, [63:32] raw_sum
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CHUNKS = VECTOR_BYTES / 8;
  localparam int LANES  = VECTOR_BYTES / 2;

  logic        mode_q;
  logic [31:0] scale_q;
  logic        adv;
  logic        q_push, q_pop;
  item_t       front_item, q_item;
  q_stat_t     q_stat;
  snap_ctl_t   snap;
  logic [LANES-1:0][15:0] snap_lanes;
  logic        sum_valid;
  logic [31:0] sum;
  logic        fp_valid;
  logic [31:0] fp_scaled, fp_raw;
  logic        out_valid_q;
  logic [63:0] out_data_q;

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SCALE) ? scale_q : {31'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_INT8;
      scale_q <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MODE) mode_q <= pwdata[0];
      else scale_q <= pwdata;
    end
  end

  qdp_front #(.VECTOR_BYTES(VECTOR_BYTES)) u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .a_i        (s_axis_tdata[63:0]),
    .b_i        (s_axis_tdata[127:64]),
    .last_i     (s_axis_tlast),
    .mode_i     (mode_q),
    .q_full_i   (q_stat.full),
    .push_o     (q_push),
    .item_o     (front_item)
  );

  // Back end moves when the output register is free or drained
  assign adv   = !out_valid_q || m_axis_tready;
  assign q_pop = adv && !q_stat.empty;

  qdp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (q_push),
    .item_i (front_item),
    .pop_i  (q_pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  qdp_lane_acc #(.VECTOR_BYTES(VECTOR_BYTES)) u_lane_acc (
    .clk_i, .rst_ni,
    .adv_i        (adv),
    .in_valid_i   (!q_stat.empty),
    .item_i       (q_item),
    .snap_o       (snap),
    .snap_lanes_o (snap_lanes)
  );

  qdp_reduce #(.VECTOR_BYTES(VECTOR_BYTES)) u_reduce (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .snap_i  (snap),
    .lanes_i (snap_lanes),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  qdp_fp_unit u_fp (
    .clk_i, .rst_ni,
    .adv_i    (adv),
    .valid_i  (sum_valid),
    .sum_i    (sum),
    .scale_i  (scale_q),
    .valid_o  (fp_valid),
    .scaled_o (fp_scaled),
    .raw_o    (fp_raw)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= fp_valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_data_q <= {fp_raw, fp_scaled};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `QDP_ASSERT(a_pos_range, clk_i, rst_ni, !q_push || (front_item.pos <= POS_W'(CHUNKS - 1)), "chunk position out of range")
  `QDP_ASSERT_NEXT(a_last_wraps, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, front_item.pos == '0, "position not cleared after last")
  `QDP_ASSERT_NEXT(a_queue_count, clk_i, rst_ni, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count lost a push")

endmodule
